// File: rtl/tdpb_pkg.sv
package tdpb_pkg;

  localparam int ARRIVAL_W = 32;
  localparam int PROC_W    = 16;
  localparam int TIME_W    = 33;
  localparam int CFG_W     = 7;

  localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 7'd64;

  // One packet request as it waits between the front queue and the engine.
  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [PROC_W-1:0]    service_time;
  } item_t;

  // Per-cycle engine status: a packet is decided this cycle, and whether it is dropped.
  typedef struct packed {
    logic decide;
    logic drop;
  } eng_stat_t;

endpackage

// File: rtl/tdpb_queue.sv
module tdpb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tdpb_pkg::item_t in_item,
  output logic            q_valid,
  output tdpb_pkg::item_t q_item,
  input  logic            q_pop
);

  tdpb_pkg::item_t ent_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic            pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// File: rtl/tdpb_engine.sv
module tdpb_engine #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tdpb_pkg::CFG_W-1:0]     buffer_size,
  input  logic                           q_valid,
  input  tdpb_pkg::item_t                q_item,
  output tdpb_pkg::eng_stat_t            stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_dropped,
  output logic [tdpb_pkg::TIME_W-1:0]    out_start
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > tdpb_pkg::CFG_W) ? CNT_W : tdpb_pkg::CFG_W;
  localparam int TW    = tdpb_pkg::TIME_W;

  logic [TW-1:0]    mem [QUEUE_DEPTH];
  logic [TW-1:0]    rd_r;
  logic             byp_r;
  logic [TW-1:0]    byp_data_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0]    last_r, last_nxt;

  logic             out_valid_r;
  logic             out_dropped_r;
  logic [TW-1:0]    out_start_r;

  logic [TW-1:0]    head_data;
  logic [TW-1:0]    arr;
  logic             retire;
  logic             out_free;
  logic             decide;
  logic             full;
  logic             push;
  logic [CMP_W-1:0] cap;
  logic [CMP_W-1:0] size_ext;
  logic [TW-1:0]    start;
  logic [TW:0]      sum;
  logic [TW-1:0]    finish;

  assign head_data = byp_r ? byp_data_r : rd_r;
  assign arr       = {1'b0, q_item.arrival};
  assign out_free  = !out_valid_r || out_ready;

  // Retire the oldest entry once it finishes at or before this arrival.
  assign retire = q_valid && (cnt_r != '0) && (head_data <= arr);
  assign decide = q_valid && !retire && out_free;

  always_comb begin
    size_ext = CMP_W'(buffer_size);
    cap      = (size_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : size_ext;
    full     = (CMP_W'(cnt_r) >= cap);
    push     = decide && !full;
    start    = ((cnt_r != '0) && (last_r > arr)) ? last_r : arr;
    sum      = {1'b0, start} + (TW + 1)'(q_item.service_time);
    finish   = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (retire) begin
      head_nxt = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    if (push) begin
      tail_nxt = (tail_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + IDX_W'(1);
      cnt_nxt  = cnt_r + CNT_W'(1);
      last_nxt = finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      // forward a write that lands on the next head slot
      byp_r  <= push && (tail_r == head_nxt);
      if (decide) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    byp_data_r <= finish;
    if (decide) begin
      out_dropped_r <= full;
      out_start_r   <= full ? '0 : start;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= finish;
    end
    rd_r <= mem[head_nxt];
  end

  assign stat.decide = decide;
  assign stat.drop   = decide && full;
  assign out_valid   = out_valid_r;
  assign out_dropped = out_dropped_r;
  assign out_start   = out_start_r;

endmodule

// File: rtl/tail_drop_packet_buffer.sv
// A request accepted into the front queue is decided at its head once every buffer entry
// finishing by its arrival has retired and the output is free; its result is registered.
// Throughput: one packet per cycle while out_ready holds and no entry retires, set by the
// single read port on the finish-time memory that walks the head one entry a cycle.
// Reset (rst_n, synchronous, active low): queues empty, buffer_size 64; the finish-time
// memory keeps its contents and is only read where written.
module tail_drop_packet_buffer #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tdpb_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tdpb_pkg::ARRIVAL_W-1:0] in_arrival,
  input  logic [tdpb_pkg::PROC_W-1:0]    in_service_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_dropped,
  output logic [tdpb_pkg::TIME_W-1:0]    out_start
);

  logic [tdpb_pkg::CFG_W-1:0] buffer_size_r;
  tdpb_pkg::item_t            in_item;
  tdpb_pkg::item_t            q_item;
  logic                       q_valid;
  tdpb_pkg::eng_stat_t        stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= tdpb_pkg::BUF_SIZE_RESET;
    end else if (cfg_wr_en) begin
      buffer_size_r <= cfg_wr_data;
    end
  end

  assign in_item.arrival      = in_arrival;
  assign in_item.service_time = in_service_time;

  tdpb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (stat.decide)
  );

  tdpb_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .buffer_size (buffer_size_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_dropped (out_dropped),
    .out_start   (out_start)
  );

`ifndef SYNTHESIS
  a_zero_size_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.decide && (buffer_size_r == '0)) |-> stat.drop)
    else $error("packet kept with zero buffer size");

  a_decide_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.decide |=> out_valid)
    else $error("decided packet produced no result");

  a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.drop |=> (out_dropped && (out_start == '0)))
    else $error("dropped packet result malformed");

  a_decide_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    stat.decide |-> q_valid)
    else $error("decision without a queued request");
`endif

endmodule
